>>> rtl/core/bap_pkg.sv
// ----------------------------------------------------------------------------
// bap_pkg
// Shared types, codes and pipeline constants of the box atlas UV projector.
// ----------------------------------------------------------------------------
package bap_pkg;

    localparam int COORD_W      = 32;
    localparam int DEF_POS_BITS = 32;
    localparam int PAD_W        = 14;
    localparam logic [PAD_W-1:0] PAD_LIMIT = 14'd13107;
    localparam int UV_W         = 16;
    localparam int CELL_W       = 3;

    localparam int NORM_LAT = 4;
    localparam int PRE_LAT  = 3;
    localparam int DIV_BITS = 18;
    localparam int DIV_NW   = 54;
    localparam int DIV_DW   = 36;

    localparam logic [CELL_W-1:0] CELL_PX = 3'd0;
    localparam logic [CELL_W-1:0] CELL_NX = 3'd1;
    localparam logic [CELL_W-1:0] CELL_PY = 3'd2;
    localparam logic [CELL_W-1:0] CELL_NY = 3'd3;
    localparam logic [CELL_W-1:0] CELL_PZ = 3'd4;
    localparam logic [CELL_W-1:0] CELL_NZ = 3'd5;

    localparam logic [2:0] REG_MIN_X    = 3'd0;
    localparam logic [2:0] REG_MIN_Y    = 3'd1;
    localparam logic [2:0] REG_MIN_Z    = 3'd2;
    localparam logic [2:0] REG_EXTENT_X = 3'd3;
    localparam logic [2:0] REG_EXTENT_Y = 3'd4;
    localparam logic [2:0] REG_EXTENT_Z = 3'd5;
    localparam logic [2:0] REG_PADDING  = 3'd6;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] min_pos;
        logic [2:0][COORD_W-1:0] extent;
        logic [PAD_W-1:0]        pad;
    } cfg_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    function automatic coord_t sext_pos(input logic [COORD_W-1:0] raw, input int bits);
        int sh;
        sh = COORD_W - bits;
        return $signed(raw << sh) >>> sh;
    endfunction

endpackage

>>> rtl/core/bap_div.sv
// ----------------------------------------------------------------------------
// bap_div
// Pipelined restoring divider: one quotient bit is settled in each stage.
// ----------------------------------------------------------------------------
module bap_div #(
    parameter int NW = 54,
    parameter int DW = 36,
    parameter int QB = 18
) (
    input  logic          aclk,
    input  logic          adv,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] quo
);
    logic [QB-1:0][NW-1:0] rem_reg;
    logic [QB-1:0][DW-1:0] den_reg;
    logic [QB-1:0][QB-1:0] quo_reg;
    logic [QB-1:0][NW-1:0] rem_w;
    logic [QB-1:0][DW-1:0] den_w;
    logic [QB-1:0][QB-1:0] quo_w;
    logic [QB-1:0][NW:0]   diff_w;

    always_comb begin
        rem_w[0] = num;
        den_w[0] = den;
        quo_w[0] = '0;
        for (int g = 1; g < QB; g++) begin
            rem_w[g] = rem_reg[g-1];
            den_w[g] = den_reg[g-1];
            quo_w[g] = quo_reg[g-1];
        end
        for (int g = 0; g < QB; g++) begin
            diff_w[g] = {1'b0, rem_w[g]} - {1'b0, NW'(den_w[g]) << (QB - 1 - g)};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int g = 0; g < QB; g++) begin
                den_reg[g] <= den_w[g];
                if (!diff_w[g][NW]) begin
                    rem_reg[g] <= diff_w[g][NW-1:0];
                    quo_reg[g] <= quo_w[g] | (QB'(1) << (QB - 1 - g));
                end else begin
                    rem_reg[g] <= rem_w[g];
                    quo_reg[g] <= quo_w[g];
                end
            end
        end
    end

    assign quo = quo_reg[QB-1];
endmodule

>>> rtl/core/bap_normal.sv
// ----------------------------------------------------------------------------
// bap_normal
// Face normal by cross product and choice of the atlas cell.
// ----------------------------------------------------------------------------
module bap_normal (
    input  logic                            aclk,
    input  logic                            adv,
    input  bap_pkg::coord_t [2:0][2:0]      pos,
    output logic [bap_pkg::CELL_W-1:0]      atlas_sel
);
    import bap_pkg::*;

    logic signed [2:0][COORD_W:0]       e1_reg, e2_reg;
    logic signed [5:0][2*COORD_W+1:0]   prod_reg;
    logic signed [2:0][2*COORD_W+2:0]   n_reg;
    logic [CELL_W-1:0]                  cell_reg;
    logic [2:0][2*COORD_W+2:0]          mag_w;
    logic [CELL_W-1:0]                  cell_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_w[i] = n_reg[i][2*COORD_W+2] ? -n_reg[i] : n_reg[i];
        end
        if (mag_w[0] >= mag_w[1] && mag_w[0] >= mag_w[2]) begin
            cell_next = n_reg[0][2*COORD_W+2] ? CELL_NX : CELL_PX;
        end else if (mag_w[1] >= mag_w[2]) begin
            cell_next = n_reg[1][2*COORD_W+2] ? CELL_NY : CELL_PY;
        end else begin
            cell_next = n_reg[2][2*COORD_W+2] ? CELL_NZ : CELL_PZ;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= (COORD_W+1)'($signed(pos[1][i]))
                             - (COORD_W+1)'($signed(pos[0][i]));
                e2_reg[i] <= (COORD_W+1)'($signed(pos[2][i]))
                             - (COORD_W+1)'($signed(pos[0][i]));
            end
            prod_reg[0] <= $signed(e1_reg[1]) * $signed(e2_reg[2]);
            prod_reg[1] <= $signed(e1_reg[2]) * $signed(e2_reg[1]);
            prod_reg[2] <= $signed(e1_reg[2]) * $signed(e2_reg[0]);
            prod_reg[3] <= $signed(e1_reg[0]) * $signed(e2_reg[2]);
            prod_reg[4] <= $signed(e1_reg[0]) * $signed(e2_reg[1]);
            prod_reg[5] <= $signed(e1_reg[1]) * $signed(e2_reg[0]);
            for (int i = 0; i < 3; i++) begin
                n_reg[i] <= (2*COORD_W+3)'($signed(prod_reg[2*i]))
                            - (2*COORD_W+3)'($signed(prod_reg[2*i+1]));
            end
            cell_reg <= cell_next;
        end
    end

    assign atlas_sel = cell_reg;
endmodule

>>> rtl/core/bap_lane.sv
// ----------------------------------------------------------------------------
// bap_lane
// One vertex lane: projection onto the cell plane, normalisation by the
// bounds, padding and placement, with one divider for u and one for v.
// ----------------------------------------------------------------------------
module bap_lane (
    input  logic                              aclk,
    input  logic                              adv,
    input  bap_pkg::cfg_t                     cfg,
    input  logic [bap_pkg::CELL_W-1:0]        atlas_sel,
    input  bap_pkg::coord_t [2:0]             pos,
    output logic [bap_pkg::DIV_BITS-1:0]      u_quo,
    output logic [bap_pkg::DIV_BITS-1:0]      v_quo
);
    import bap_pkg::*;

    localparam int NUMW = COORD_W;
    localparam int KW   = 18;
    localparam int MW   = 17;

    logic [1:0][NUMW-1:0]      num_reg, den_reg;
    logic [1:0][KW-1:0]        k_reg;
    logic [1:0]                three_reg;
    logic [MW-1:0]             m_reg;
    logic [1:0][NUMW+KW-1:0]   pk_reg;
    logic [1:0][NUMW+MW-1:0]   pm_reg;
    logic [1:0][NUMW+1:0]      bot_reg;
    logic [1:0][DIV_NW-1:0]    dnum_reg;
    logic [1:0][DIV_DW-1:0]    dden_reg;

    logic [1:0][1:0]           axis_w;
    logic [1:0]                flip_w;
    logic [1:0][NUMW-1:0]      num_w, den_w;
    logic [1:0][1:0]           slot_w;
    logic [PAD_W-1:0]          pad_w;

    always_comb begin
        pad_w = (cfg.pad > PAD_LIMIT) ? PAD_LIMIT : cfg.pad;
        axis_w = '0;
        flip_w = '0;
        slot_w = '0;
        case (atlas_sel)
            CELL_PX: begin
                axis_w[0] = 2'd2; flip_w[0] = 1'b1; axis_w[1] = 2'd1;
                slot_w[0] = 2'd0; slot_w[1] = 2'd0;
            end
            CELL_NX: begin
                axis_w[0] = 2'd2; axis_w[1] = 2'd1;
                slot_w[0] = 2'd1; slot_w[1] = 2'd0;
            end
            CELL_PY: begin
                axis_w[0] = 2'd0; axis_w[1] = 2'd2; flip_w[1] = 1'b1;
                slot_w[0] = 2'd2; slot_w[1] = 2'd0;
            end
            CELL_NY: begin
                axis_w[0] = 2'd0; axis_w[1] = 2'd2;
                slot_w[0] = 2'd0; slot_w[1] = 2'd1;
            end
            CELL_PZ: begin
                axis_w[0] = 2'd0; axis_w[1] = 2'd1;
                slot_w[0] = 2'd1; slot_w[1] = 2'd1;
            end
            default: begin
                axis_w[0] = 2'd0; flip_w[0] = 1'b1; axis_w[1] = 2'd1;
                slot_w[0] = 2'd2; slot_w[1] = 2'd1;
            end
        endcase
        for (int j = 0; j < 2; j++) begin
            logic signed [NUMW+2:0] mn, ex, pp, diff;
            mn = (NUMW+3)'($signed(cfg.min_pos[axis_w[j]]));
            ex = (NUMW+3)'({1'b0, cfg.extent[axis_w[j]]});
            pp = (NUMW+3)'($signed(pos[axis_w[j]]));
            diff = flip_w[j] ? (mn + ex - pp) : (pp - mn);
            if (cfg.extent[axis_w[j]] == '0) begin
                num_w[j] = NUMW'(1);
                den_w[j] = NUMW'(2);
            end else begin
                den_w[j] = cfg.extent[axis_w[j]];
                if (diff < 0) begin
                    num_w[j] = '0;
                end else if (diff > ex) begin
                    num_w[j] = cfg.extent[axis_w[j]];
                end else begin
                    num_w[j] = diff[NUMW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_reg <= MW'(65536) - MW'({pad_w, 1'b0});
            for (int j = 0; j < 2; j++) begin
                num_reg[j] <= num_w[j];
                den_reg[j] <= den_w[j];
                k_reg[j]   <= {slot_w[j], 16'd0} + KW'(pad_w);
            end
            three_reg <= 2'b01;
            for (int j = 0; j < 2; j++) begin
                pk_reg[j]  <= den_reg[j] * k_reg[j];
                pm_reg[j]  <= num_reg[j] * m_reg;
                bot_reg[j] <= three_reg[j] ? ((NUMW+2)'(den_reg[j]) * (NUMW+2)'(3))
                                           : ((NUMW+2)'(den_reg[j]) << 1);
            end
            for (int j = 0; j < 2; j++) begin
                dnum_reg[j] <= ((DIV_NW'(pk_reg[j]) + DIV_NW'(pm_reg[j])) << 1)
                               + DIV_NW'(bot_reg[j]);
                dden_reg[j] <= DIV_DW'(bot_reg[j]) << 1;
            end
        end
    end

    bap_div #(.NW(DIV_NW), .DW(DIV_DW), .QB(DIV_BITS)) u_div_u (
        .aclk (aclk), .adv (adv), .num (dnum_reg[0]), .den (dden_reg[0]), .quo (u_quo)
    );

    bap_div #(.NW(DIV_NW), .DW(DIV_DW), .QB(DIV_BITS)) u_div_v (
        .aclk (aclk), .adv (adv), .num (dnum_reg[1]), .den (dden_reg[1]), .quo (v_quo)
    );
endmodule

>>> rtl/core/box_atlas_uv_projector.sv
// ----------------------------------------------------------------------------
// box_atlas_uv_projector
// Box projection of one triangle into a six-cell atlas of three columns by
// two rows, giving the cell and one UV pair per vertex.
// ----------------------------------------------------------------------------
// Usage: a triangle arrives as one beat on the s_ channel, nine signed Q16.16
// coordinates in s_tdata. One result beat leaves on the m_ channel with the
// atlas cell and six unsigned Q0.16 coordinates in m_tdata.
// The bounds and padding are written through cfg_we, cfg_index and cfg_wdata
// while no triangle is in flight.
// Throughput is one triangle per cycle while the receiver does not stall.
// The input register loads at the accepting edge, followed by four stages
// for the normal and the cell, three for the ratios and products, eighteen
// in the restoring dividers (one quotient bit per stage) and the output
// register.
// Three vertex lanes, each with a divider for u and one for v, run together.
// Reset clears all valid flags and the configuration registers to zero.
// When the receiver stalls, the whole pipeline holds and s_tready falls.
// ----------------------------------------------------------------------------
module box_atlas_uv_projector #(
    parameter int POSITION_BITS = bap_pkg::DEF_POS_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, first_z, second_x, .., third_z, 32 bits each
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // atlas_cell[2:0], first_u, first_v, second_u, second_v, third_u, third_v
    output logic [103:0] m_tdata
);
    import bap_pkg::*;

    localparam int PW  = (POSITION_BITS < 16) ? 16 : ((POSITION_BITS > 32) ? 32 : POSITION_BITS);
    localparam int LAT = 1 + NORM_LAT + PRE_LAT + DIV_BITS;

    logic                          adv;
    cfg_t                          cfg_reg;
    logic [LAT-1:0]                vld_reg;
    logic                          out_valid_reg;
    logic [103:0]                  out_data_reg;
    coord_t [NORM_LAT:0][2:0][2:0] pos_reg;
    logic [LAT-1:NORM_LAT+1][CELL_W-1:0] cell_reg;
    logic [CELL_W-1:0]             cell_w;
    logic [2:0][DIV_BITS-1:0]      u_quo_w, v_quo_w;
    logic [2:0][UV_W-1:0]          u_sat_w, v_sat_w;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MIN_X:    cfg_reg.min_pos[0] <= cfg_wdata;
                REG_MIN_Y:    cfg_reg.min_pos[1] <= cfg_wdata;
                REG_MIN_Z:    cfg_reg.min_pos[2] <= cfg_wdata;
                REG_EXTENT_X: cfg_reg.extent[0]  <= cfg_wdata;
                REG_EXTENT_Y: cfg_reg.extent[1]  <= cfg_wdata;
                REG_EXTENT_Z: cfg_reg.extent[2]  <= cfg_wdata;
                REG_PADDING:  cfg_reg.pad        <= cfg_wdata[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg       <= {vld_reg[LAT-2:0], s_tvalid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    pos_reg[0][k][i] <= sext_pos(s_tdata[(3*k+i)*COORD_W +: COORD_W], PW);
                end
            end
            for (int s = 1; s <= NORM_LAT; s++) begin
                pos_reg[s] <= pos_reg[s-1];
            end
            cell_reg[NORM_LAT+1] <= cell_w;
            for (int s = NORM_LAT + 2; s < LAT; s++) begin
                cell_reg[s] <= cell_reg[s-1];
            end
            out_data_reg <= {5'd0, v_sat_w[2], u_sat_w[2], v_sat_w[1], u_sat_w[1],
                             v_sat_w[0], u_sat_w[0], cell_reg[LAT-1]};
        end
    end

    bap_normal u_normal (
        .aclk (aclk), .adv (adv), .pos (pos_reg[0]), .atlas_sel (cell_w)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        bap_lane u_lane (
            .aclk      (aclk),
            .adv       (adv),
            .cfg       (cfg_reg),
            .atlas_sel (cell_w),
            .pos       (pos_reg[NORM_LAT][k]),
            .u_quo     (u_quo_w[k]),
            .v_quo     (v_quo_w[k])
        );
        assign u_sat_w[k] = (u_quo_w[k] > DIV_BITS'(16'hFFFF)) ? 16'hFFFF : u_quo_w[k][UV_W-1:0];
        assign v_sat_w[k] = (v_quo_w[k] > DIV_BITS'(16'hFFFF)) ? 16'hFFFF : v_quo_w[k][UV_W-1:0];
    end
endmodule
